/* rtl/core/json_subset_stream_validator_defines.svh */
// Assertion macros used by the checker file.
`ifndef JSON_SUBSET_STREAM_VALIDATOR_DEFINES_SVH
`define JSON_SUBSET_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define JSSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jssv check failed");

// Next-cycle implication, sampled on clk_i, idle during reset.
`define JSSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jssv check failed");

`endif

/* rtl/core/jssv_pkg.sv */
`default_nettype none

package jssv_pkg;

  // Fixed field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ERR_W    = 4;
  localparam int unsigned BEV_W    = 3;
  localparam int unsigned VD_W     = 3;
  localparam int unsigned DEPTH_W  = 6;
  localparam int unsigned LPOS_W   = 3;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_KEY       = 4'd1,
    PH_KEYCHARS  = 4'd2,
    PH_COLON     = 4'd3,
    PH_VALUE     = 4'd4,
    PH_ARR_FIRST = 4'd5,
    PH_STRING    = 4'd6,
    PH_NUMBER    = 4'd7,
    PH_LITERAL   = 4'd8,
    PH_AFTER     = 4'd9,
    PH_DONE      = 4'd10
  } phase_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_BRACE    = 4'd1,
    ERR_BAD_KEY     = 4'd2,
    ERR_NO_COLON    = 4'd3,
    ERR_BAD_VALUE   = 4'd4,
    ERR_BAD_LITERAL = 4'd5,
    ERR_BAD_OBJECT  = 4'd6,
    ERR_BAD_ARRAY   = 4'd7,
    ERR_NEWLINE     = 4'd8,
    ERR_OVERFLOW    = 4'd9,
    ERR_TRUNCATED   = 4'd10
  } err_e;

  typedef enum logic [BEV_W-1:0] {
    BEV_NONE      = 3'd0,
    BEV_OPEN_OBJ  = 3'd1,
    BEV_CLOSE_OBJ = 3'd2,
    BEV_OPEN_ARR  = 3'd3,
    BEV_CLOSE_ARR = 3'd4
  } bev_e;

  typedef enum logic [VD_W-1:0] {
    VD_NONE   = 3'd0,
    VD_KEY    = 3'd1,
    VD_STRING = 3'd2,
    VD_NUMBER = 3'd3,
    VD_BOOL   = 3'd4
  } vd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN    = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  // Result word handed from the parser to the output buffer.
  typedef struct packed {
    status_e            status;
    err_e               err;
    bev_e               bev;
    vd_e                vd;
    logic [DEPTH_W-1:0] depth;
  } res_t;

  // Stack shift command from the parser to the cell chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic bit_in;   // 1 for an array level, 0 for an object level
  } stk_op_t;

  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_E      = 8'h65;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h61;
  localparam logic [BYTE_W-1:0] CH_L      = 8'h6C;
  localparam logic [BYTE_W-1:0] CH_S      = 8'h73;

  localparam logic [LPOS_W-1:0] LIT_LEN_TRUE  = 3'd4;
  localparam logic [LPOS_W-1:0] LIT_LEN_FALSE = 3'd5;

  function automatic logic is_ws(logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(logic [BYTE_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_plain(logic [BYTE_W-1:0] c);
    return !(is_ws(c) || is_digit(c) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
             (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_COLON) ||
             (c == CH_COMMA) || (c == CH_QUOTE));
  endfunction

  // Expected letter of a literal at a given position.
  function automatic logic [BYTE_W-1:0] lit_char(logic is_false, logic [LPOS_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    case ({is_false, pos})
      4'b0_000: ch = CH_T;
      4'b0_001: ch = CH_R;
      4'b0_010: ch = CH_U;
      4'b0_011: ch = CH_E;
      4'b1_000: ch = CH_F;
      4'b1_001: ch = CH_A;
      4'b1_010: ch = CH_L;
      4'b1_011: ch = CH_S;
      4'b1_100: ch = CH_E;
      default:  ch = '0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jssv_if.sv */
`default_nettype none

// Input channel: one document byte per word.
interface jssv_in_if import jssv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_req;
  logic              last;

  modport source (output valid, output byte_req, output last, input ready);
  modport sink   (input valid, input byte_req, input last, output ready);
endinterface

// Output channel: one result word per input word.
interface jssv_out_if import jssv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ERR_W-1:0]    error_code;
  logic [BEV_W-1:0]    bracket_event;
  logic [VD_W-1:0]     value_done;
  logic [DEPTH_W-1:0]  depth;

  modport source (output valid, output status, output error_code, output bracket_event,
                  output value_done, output depth, input ready);
  modport sink   (input valid, input status, input error_code, input bracket_event,
                  input value_done, input depth, output ready);
endinterface

`default_nettype wire

/* rtl/core/json_subset_stream_validator.sv */
`default_nettype none

// Streaming validator for a subset of JSON text.
// in_i  : one document byte per word (byte_req) with last on the final byte.
// out_o : one result word per input word, in order: status, error_code,
//         bracket_event, value_done and the nesting depth after that byte.
// The result of a byte is registered in the output word, or in the skid word while out_o stalls.
// Throughput: one byte per cycle, sustained, as long as out_o is drained.
// The nesting stack is a chain of MAX_DEPTH one-bit cells that shift toward
// the deep end on an open bracket and back on a close; the top of the stack
// is always cell 0, so the per-byte decision needs no addressed memory.
// Reset clears the parser to "expect opening brace" with depth 0 and empties
// the output stage; the stack cells need no clearing, only pushed levels are
// ever read. After the last byte of a document the parser starts afresh.
// When out_o stalls, a skid word absorbs one more result, then in_i.ready
// drops until the receiver takes a word.
module json_subset_stream_validator import jssv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jssv_in_if.sink    in_i,
  jssv_out_if.source out_o
);

  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);

  logic     accept;
  logic     stk_en;
  res_t     res;
  stk_op_t  op;

  logic [MAX_DEPTH-1:0] cell_bits;
  logic [MAX_DEPTH-1:0] prev_vec;
  logic [MAX_DEPTH-1:0] next_vec;

  // Output stage: main word plus one skid word.
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_vld_q, out_vld_d;
  logic skid_vld_q, skid_vld_d;
  logic out_free;

  // Take a byte whenever the skid word is empty.
  assign in_i.ready = !skid_vld_q;
  assign accept     = in_i.valid && in_i.ready;

  jssv_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .LVL_W     (LVL_W)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.byte_req),
    .last_i   (in_i.last),
    .top_i    (cell_bits[0]),
    .res_o    (res),
    .op_o     (op)
  );

  // Stack chain: cell 0 is the top level, a push feeds it from the parser.
  assign stk_en   = accept && (op.push || op.pop);
  assign prev_vec = {cell_bits[MAX_DEPTH-2:0], op.bit_in};
  assign next_vec = {1'b0, cell_bits[MAX_DEPTH-1:1]};

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    jssv_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (stk_en),
      .push_i     (op.push),
      .prev_i     (prev_vec[i]),
      .next_i     (next_vec[i]),
      .bit_o      (cell_bits[i])
    );
  end

  // Advance the output stage: drain skid first to keep order.
  always_comb begin
    out_free   = !out_vld_q || out_o.ready;
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = accept;
      end
    end else if (accept) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = out_q.status;
  assign out_o.error_code    = out_q.err;
  assign out_o.bracket_event = out_q.bev;
  assign out_o.value_done    = out_q.vd;
  assign out_o.depth         = out_q.depth;

endmodule

`default_nettype wire

/* rtl/core/jssv_cell.sv */
`default_nettype none

// One level of the container stack. On push take the bit from the cell above
// the top side, on pop take the bit from the deeper neighbor.
module jssv_cell (
  input  wire logic clk_i,
  input  wire logic shift_en_i,
  input  wire logic push_i,
  input  wire logic prev_i,
  input  wire logic next_i,
  output logic      bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      bit_q <= push_i ? prev_i : next_i;
    end
  end

  assign bit_o = bit_q;

endmodule

`default_nettype wire

/* rtl/core/jssv_ctrl.sv */
`default_nettype none

// Parser state and per-byte decision. Stack top comes from cell 0.
module jssv_ctrl import jssv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32,
  parameter int unsigned LVL_W     = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              last_i,
  input  wire logic              top_i,
  output res_t                   res_o,
  output stk_op_t                op_o
);

  phase_e            phase_q, phase_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [LPOS_W-1:0] lpos_q, lpos_d;
  logic              lfalse_q, lfalse_d;
  logic              jopen_q, jopen_d;
  err_e              err_q, err_d;

  // Work values of one byte, before the end-of-document reset.
  phase_e            ph_w;
  logic [LVL_W-1:0]  lvl_w;
  logic [LPOS_W-1:0] lpos_w;
  logic              lfalse_w;
  logic              jopen_w;
  err_e              err_w;
  err_e              fail;
  bev_e              ev;
  vd_e               vd;
  logic              do_start, do_after, do_open, do_close, lvl_is_arr, shut_is_arr;
  logic              lit_ok;
  logic [LPOS_W-1:0] lit_len, lpos_inc;
  logic [LVL_W+DEPTH_W-1:0] depth_ext;

  always_comb begin
    ph_w        = phase_q;
    lvl_w       = level_q;
    lpos_w      = lpos_q;
    lfalse_w    = lfalse_q;
    jopen_w     = jopen_q;
    err_w       = err_q;
    fail        = ERR_NONE;
    ev          = BEV_NONE;
    vd          = VD_NONE;
    do_start    = 1'b0;
    do_after    = 1'b0;
    do_open     = 1'b0;
    do_close    = 1'b0;
    lvl_is_arr  = 1'b0;
    shut_is_arr = 1'b0;
    op_o        = '0;
    lit_len     = lfalse_q ? LIT_LEN_FALSE : LIT_LEN_TRUE;
    lpos_inc    = lpos_q + LPOS_W'(1);
    lit_ok      = (lpos_q < lit_len) && (byte_i == lit_char(lfalse_q, lpos_q));

    if (err_q == ERR_NONE) begin
      case (phase_q)
        PH_START: begin
          if (byte_i == CH_LBRACE) begin
            do_open = 1'b1;
          end else if (!is_ws(byte_i)) begin
            fail = ERR_NO_BRACE;
          end
        end
        PH_KEY: begin
          if (byte_i == CH_QUOTE) begin
            ph_w = PH_KEYCHARS;
          end else if (byte_i == CH_RBRACE && jopen_q) begin
            do_close = 1'b1;
          end else if (!is_ws(byte_i)) begin
            fail = ERR_BAD_KEY;
          end
        end
        PH_KEYCHARS: begin
          if (byte_i == CH_QUOTE) begin
            vd   = VD_KEY;
            ph_w = PH_COLON;
          end else if (!is_plain(byte_i)) begin
            fail = ERR_BAD_KEY;
          end
        end
        PH_COLON: begin
          if (byte_i == CH_COLON) begin
            ph_w = PH_VALUE;
          end else if (!is_ws(byte_i)) begin
            fail = ERR_NO_COLON;
          end
        end
        PH_VALUE: begin
          do_start = !is_ws(byte_i);
        end
        PH_ARR_FIRST: begin
          if (byte_i == CH_RBRACK) begin
            do_close    = 1'b1;
            shut_is_arr = 1'b1;
          end else begin
            do_start = !is_ws(byte_i);
          end
        end
        PH_STRING: begin
          if (byte_i == CH_QUOTE) begin
            vd   = VD_STRING;
            ph_w = PH_AFTER;
          end else if (byte_i == CH_LF) begin
            fail = ERR_NEWLINE;
          end
        end
        PH_NUMBER: begin
          if (!is_digit(byte_i)) begin
            vd       = VD_NUMBER;
            ph_w     = PH_AFTER;
            do_after = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (lit_ok) begin
            lpos_w = lpos_inc;
            if (lpos_inc == lit_len) begin
              vd     = VD_BOOL;
              lpos_w = '0;
              ph_w   = PH_AFTER;
            end
          end else begin
            fail = ERR_BAD_LITERAL;
          end
        end
        PH_AFTER: begin
          do_after = 1'b1;
        end
        PH_DONE: begin
          if (!is_ws(byte_i)) begin
            fail = ERR_TRUNCATED;
          end
        end
        default: begin
          fail = ERR_TRUNCATED;
        end
      endcase
    end

    // Start of a value.
    if (do_start) begin
      if (byte_i == CH_LBRACE) begin
        do_open = 1'b1;
      end else if (byte_i == CH_LBRACK) begin
        do_open    = 1'b1;
        lvl_is_arr = 1'b1;
      end else if (byte_i == CH_QUOTE) begin
        ph_w = PH_STRING;
      end else if (is_digit(byte_i)) begin
        ph_w = PH_NUMBER;
      end else if (byte_i == CH_T || byte_i == CH_F) begin
        lfalse_w = (byte_i == CH_F);
        lpos_w   = LPOS_W'(1);
        ph_w     = PH_LITERAL;
      end else begin
        fail = ERR_BAD_VALUE;
      end
    end

    // Byte after a finished value: separator or closing bracket.
    if (do_after && !is_ws(byte_i)) begin
      if (level_q == '0) begin
        fail = ERR_TRUNCATED;
      end else if (byte_i == CH_COMMA) begin
        if (top_i) begin
          ph_w = PH_VALUE;
        end else begin
          ph_w    = PH_KEY;
          jopen_w = 1'b0;
        end
      end else if (!top_i && byte_i == CH_RBRACE) begin
        do_close = 1'b1;
      end else if (top_i && byte_i == CH_RBRACK) begin
        do_close    = 1'b1;
        shut_is_arr = 1'b1;
      end else begin
        fail = top_i ? ERR_BAD_ARRAY : ERR_BAD_OBJECT;
      end
    end

    if (do_open) begin
      if (level_q == LVL_W'(MAX_DEPTH)) begin
        fail = ERR_OVERFLOW;
      end else begin
        op_o.push   = 1'b1;
        op_o.bit_in = lvl_is_arr;
        lvl_w       = level_q + LVL_W'(1);
        if (lvl_is_arr) begin
          ev   = BEV_OPEN_ARR;
          ph_w = PH_ARR_FIRST;
        end else begin
          ev      = BEV_OPEN_OBJ;
          ph_w    = PH_KEY;
          jopen_w = 1'b1;
        end
      end
    end

    if (do_close) begin
      if (level_q == '0) begin
        fail = ERR_TRUNCATED;
      end else begin
        op_o.pop = 1'b1;
        lvl_w    = level_q - LVL_W'(1);
        ev       = shut_is_arr ? BEV_CLOSE_ARR : BEV_CLOSE_OBJ;
        ph_w     = (level_q == LVL_W'(1)) ? PH_DONE : PH_AFTER;
      end
    end

    if (fail != ERR_NONE) begin
      err_w = fail;
      ev    = BEV_NONE;
      vd    = VD_NONE;
    end

    // End of document while still open.
    if (err_w == ERR_NONE && last_i && ph_w != PH_DONE) begin
      err_w = ERR_TRUNCATED;
      ev    = BEV_NONE;
      vd    = VD_NONE;
    end

    depth_ext = {{DEPTH_W{1'b0}}, lvl_w};

    res_o.err   = err_w;
    res_o.bev   = ev;
    res_o.vd    = vd;
    res_o.depth = depth_ext[DEPTH_W-1:0];
    if (err_w != ERR_NONE) begin
      res_o.status = ST_ERROR;
    end else if (last_i && ph_w == PH_DONE) begin
      res_o.status = ST_ACCEPT;
    end else begin
      res_o.status = ST_RUN;
    end
  end

  // Next state: start afresh after the last byte.
  always_comb begin
    if (last_i) begin
      phase_d  = PH_START;
      level_d  = '0;
      lpos_d   = '0;
      lfalse_d = 1'b0;
      jopen_d  = 1'b0;
      err_d    = ERR_NONE;
    end else begin
      phase_d  = ph_w;
      level_d  = lvl_w;
      lpos_d   = lpos_w;
      lfalse_d = lfalse_w;
      jopen_d  = jopen_w;
      err_d    = err_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      level_q  <= '0;
      lpos_q   <= '0;
      lfalse_q <= 1'b0;
      jopen_q  <= 1'b0;
      err_q    <= ERR_NONE;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      level_q  <= level_d;
      lpos_q   <= lpos_d;
      lfalse_q <= lfalse_d;
      jopen_q  <= jopen_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jssv_checker.sv */
`default_nettype none

`include "json_subset_stream_validator_defines.svh"

// Port-level checks on the validator.
module jssv_checker import jssv_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [ERR_W-1:0]    error_code_i,
  input wire logic [BEV_W-1:0]    bracket_event_i,
  input wire logic [VD_W-1:0]     value_done_i,
  input wire logic [DEPTH_W-1:0]  depth_i
);

  logic err_shown;
  logic no_events;
  logic [STATUS_W+ERR_W+BEV_W+VD_W+DEPTH_W-1:0] out_word;

  assign err_shown = (status_i == ST_ERROR);
  assign no_events = (bracket_event_i == BEV_NONE) && (value_done_i == VD_NONE);
  assign out_word  = {status_i, error_code_i, bracket_event_i, value_done_i, depth_i};

  // Hold a stalled result word.
  `JSSV_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word))

  // Error status and a nonzero code go together.
  `JSSV_ASSERT_IMP(a_err_code, out_valid_i, err_shown == (error_code_i != ERR_NONE))

  // Drop all events once an error is shown.
  `JSSV_ASSERT_IMP(a_err_quiet, out_valid_i && err_shown, no_events)

  // An accepted document ends balanced.
  `JSSV_ASSERT_IMP(a_accept_flat, out_valid_i && (status_i == ST_ACCEPT), depth_i == '0)

endmodule

bind json_subset_stream_validator jssv_checker u_jssv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .error_code_i    (out_o.error_code),
  .bracket_event_i (out_o.bracket_event),
  .value_done_i    (out_o.value_done),
  .depth_i         (out_o.depth)
);

`default_nettype wire
